FILE: design/gf2_cubic_tensor_transvection_defines.svh
// ----------------------------------------------------------------------------
// gf2_cubic_tensor_transvection_defines
// assertion macros of the tensor store controller
// ----------------------------------------------------------------------------
`ifndef GF2_CUBIC_TENSOR_TRANSVECTION_DEFINES_SVH
`define GF2_CUBIC_TENSOR_TRANSVECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCT_ASSERT_IMP(label, ante, cons, msg)
`define GCT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: design/gct_pkg.sv
// ----------------------------------------------------------------------------
// gct_pkg
// types, constants and key function of the cubic tensor store
// ----------------------------------------------------------------------------
package gct_pkg;

    localparam int NumIdx  = 16;
    localparam int IdxW    = 4;
    localparam int KeyW    = 3 * IdxW;
    localparam int MapDepth = NumIdx * NumIdx * NumIdx;
    localparam int CountW  = 10;
    localparam int DeltaW  = 8;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_APPLY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // read address select
    localparam logic [1:0] RD_LOAD = 2'd0;
    localparam logic [1:0] RD_SRC  = 2'd1;
    localparam logic [1:0] RD_TGT  = 2'd2;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [IdxW-1:0] triple_a;
        logic [IdxW-1:0] triple_b;
        logic [IdxW-1:0] triple_c;
        logic [IdxW-1:0] source_index;
        logic [IdxW-1:0] target_index;
    } req_t;

    typedef struct packed {
        logic signed [DeltaW-1:0] nnz_delta;
        logic [CountW-1:0]        nnz_after;
        logic                     status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       sweep_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       ld_write;
        logic       tgt_step;
        logic       pair_adv;
        logic       set_status;
        logic       emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       dup;
        logic       sweep_last;
        logic       skip;
        logic       present;
        logic       eligible;
        logic       last_pair;
        logic       out_free;
    } sts_t;

    // map key of the sorted triple
    function automatic logic [KeyW-1:0] sort_key(input logic [IdxW-1:0] a,
                                                 input logic [IdxW-1:0] b,
                                                 input logic [IdxW-1:0] c);
        logic [IdxW-1:0] p;
        logic [IdxW-1:0] q;
        logic [IdxW-1:0] r;
        logic [IdxW-1:0] t;
        p = a;
        q = b;
        r = c;
        if (p > q)
        begin
            t = p; p = q; q = t;
        end
        if (q > r)
        begin
            t = q; q = r; r = t;
        end
        if (p > q)
        begin
            t = p; p = q; q = t;
        end
        return {p, q, r};
    endfunction

endpackage

FILE: design/gct_ram.sv
// ----------------------------------------------------------------------------
// gct_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module gct_ram #(
    parameter int Width = 1,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gct_datapath.sv
// ----------------------------------------------------------------------------
// gct_datapath
// request registers, pair walk, presence map, count and result register
// ----------------------------------------------------------------------------
module gct_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  gct_pkg::req_t req,
    input  gct_pkg::cmd_t cmd,
    output gct_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gct_pkg::rsp_t rsp
);

    localparam logic [gct_pkg::IdxW-1:0] XLast = gct_pkg::IdxW'(gct_pkg::NumIdx - 2);
    localparam logic [gct_pkg::IdxW-1:0] YLast = gct_pkg::IdxW'(gct_pkg::NumIdx - 1);

    gct_pkg::req_t                    req_reg;
    logic [gct_pkg::IdxW-1:0]         x_reg;
    logic [gct_pkg::IdxW-1:0]         y_reg;
    logic [gct_pkg::KeyW-1:0]         sweep_reg;
    logic signed [gct_pkg::DeltaW-1:0] delta_reg;
    logic [gct_pkg::CountW-1:0]       count_reg;
    logic                             stat_reg;
    logic                             rsp_valid_reg;
    gct_pkg::rsp_t                    rsp_reg;

    logic [gct_pkg::KeyW-1:0] load_key;
    logic [gct_pkg::KeyW-1:0] src_key;
    logic [gct_pkg::KeyW-1:0] tgt_key;
    logic                     we;
    logic [gct_pkg::KeyW-1:0] waddr;
    logic                     wdata;
    logic [gct_pkg::KeyW-1:0] raddr;
    logic                     rdata;
    logic [gct_pkg::CountW-1:0] after_val;

    // keys of the three accesses
    assign load_key = gct_pkg::sort_key(req_reg.triple_a, req_reg.triple_b, req_reg.triple_c);
    assign src_key  = gct_pkg::sort_key(req_reg.source_index, x_reg, y_reg);
    assign tgt_key  = gct_pkg::sort_key(req_reg.target_index, x_reg, y_reg);

    // write port select
    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = 1'b0;
        if (cmd.sweep_step)
        begin
            we = 1'b1;
        end
        else if (cmd.ld_write)
        begin
            we    = 1'b1;
            waddr = load_key;
            wdata = 1'b1;
        end
        else if (cmd.tgt_step && req_reg.req_type == gct_pkg::REQ_APPLY)
        begin
            we    = 1'b1;
            waddr = tgt_key;
            wdata = ~rdata;
        end
    end

    // read port select
    always_comb
    begin
        case (cmd.rd_sel)
            gct_pkg::RD_LOAD: raddr = load_key;
            gct_pkg::RD_SRC:  raddr = src_key;
            gct_pkg::RD_TGT:  raddr = tgt_key;
            default:          raddr = load_key;
        endcase
    end

    gct_ram #(
        .Width(1),
        .Depth(gct_pkg::MapDepth)
    ) u_map (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
    end

    // pair walk, sweep address, delta, status and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= gct_pkg::IdxW'(1);
            sweep_reg <= '0;
            delta_reg <= '0;
            stat_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                x_reg     <= '0;
                y_reg     <= gct_pkg::IdxW'(1);
                sweep_reg <= '0;
                delta_reg <= '0;
                stat_reg  <= 1'b0;
                if (req.req_type == gct_pkg::REQ_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + gct_pkg::KeyW'(1);
            end
            if (cmd.pair_adv)
            begin
                if (y_reg == YLast)
                begin
                    x_reg <= x_reg + gct_pkg::IdxW'(1);
                    y_reg <= x_reg + gct_pkg::IdxW'(2);
                end
                else
                begin
                    y_reg <= y_reg + gct_pkg::IdxW'(1);
                end
            end
            if (cmd.tgt_step)
            begin
                delta_reg <= rdata ? delta_reg - gct_pkg::DeltaW'(1)
                                   : delta_reg + gct_pkg::DeltaW'(1);
            end
            if (cmd.set_status)
            begin
                stat_reg <= 1'b1;
            end
            if (cmd.ld_write)
            begin
                count_reg <= count_reg + gct_pkg::CountW'(1);
            end
            if (cmd.emit && req_reg.req_type == gct_pkg::REQ_APPLY)
            begin
                count_reg <= after_val;
            end
        end
    end

    assign after_val = count_reg +
                       {{(gct_pkg::CountW - gct_pkg::DeltaW){delta_reg[gct_pkg::DeltaW-1]}},
                        delta_reg};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.nnz_delta <= delta_reg;
            rsp_reg.nnz_after <= after_val;
            rsp_reg.status    <= stat_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status to controller
    assign sts.req_type   = req_reg.req_type;
    assign sts.dup        = (req_reg.triple_a == req_reg.triple_b) ||
                            (req_reg.triple_b == req_reg.triple_c) ||
                            (req_reg.triple_a == req_reg.triple_c);
    assign sts.sweep_last = (sweep_reg == gct_pkg::KeyW'(gct_pkg::MapDepth - 1));
    assign sts.skip       = (x_reg == req_reg.source_index) || (y_reg == req_reg.source_index);
    assign sts.present    = rdata;
    assign sts.eligible   = (req_reg.source_index == req_reg.target_index) ||
                            ((req_reg.target_index != x_reg) && (req_reg.target_index != y_reg));
    assign sts.last_pair  = (x_reg == XLast) && (y_reg == YLast);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

endmodule

FILE: design/gct_ctrl.sv
// ----------------------------------------------------------------------------
// gct_ctrl
// request sequencer: clearing pass, load, pair walk and result transfer
// ----------------------------------------------------------------------------
`include "gf2_cubic_tensor_transvection_defines.svh"

module gct_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gct_pkg::sts_t sts,
    output gct_pkg::cmd_t cmd
);

    localparam logic [3:0] S_RCLR  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LDRD  = 4'd2;
    localparam logic [3:0] S_LDWR  = 4'd3;
    localparam logic [3:0] S_TSRC  = 4'd4;
    localparam logic [3:0] S_TSCHK = 4'd5;
    localparam logic [3:0] S_TTCHK = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_DISP  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = gct_pkg::RD_LOAD;
        req_stall  = 1'b1;
        case (state_reg)
            S_RCLR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            // branch on the latched request type, no command issued
            S_DISP:
            begin
                case (sts.req_type)
                    gct_pkg::REQ_LOAD:  state_next = S_LDRD;
                    gct_pkg::REQ_CLEAR: state_next = S_CLR;
                    default:            state_next = S_TSRC;
                endcase
            end
            S_LDRD:
            begin
                if (sts.dup)
                begin
                    cmd.set_status = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LDWR;
                end
            end
            S_LDWR:
            begin
                cmd.ld_write = !sts.present;
                state_next   = S_DONE;
            end
            S_TSRC:
            begin
                if (sts.skip)
                begin
                    cmd.pair_adv = !sts.last_pair;
                    state_next   = sts.last_pair ? S_DONE : S_TSRC;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = gct_pkg::RD_SRC;
                    state_next = S_TSCHK;
                end
            end
            S_TSCHK:
            begin
                if (sts.present && sts.eligible)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = gct_pkg::RD_TGT;
                    state_next = S_TTCHK;
                end
                else
                begin
                    cmd.pair_adv = !sts.last_pair;
                    state_next   = sts.last_pair ? S_DONE : S_TSRC;
                end
            end
            S_TTCHK:
            begin
                cmd.tgt_step = 1'b1;
                cmd.pair_adv = !sts.last_pair;
                state_next   = sts.last_pair ? S_DONE : S_TSRC;
            end
            S_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RCLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `GCT_ASSERT_IMP(a_take_idle, !req_stall, state_reg == S_IDLE, "request taken outside idle")
    `GCT_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "result issued into a full register")
    `GCT_ASSERT_NXT(a_rclr_exit, state_reg == S_RCLR && sts.sweep_last, state_reg == S_IDLE, "no exit")
    `GCT_ASSERT_NXT(a_accept_disp, cmd.accept, state_reg == S_DISP, "dispatch missed after transfer")

endmodule

FILE: design/gf2_cubic_tensor_transvection.sv
// ----------------------------------------------------------------------------
// gf2_cubic_tensor_transvection
// symmetric cubic gf(2) tensor store with transvection query and apply
// ----------------------------------------------------------------------------
// One request at a time; every request gives exactly one result. The presence
// map sits in a 4096 x 1 ram with one read and one write port, and the rate is
// set by that read port. After reset a clearing pass over all 4096 entries runs
// before the first request is taken. A load is rejected when two of its indices
// are equal; a clear request sweeps the whole map again. Query and apply walk
// all 120 index pairs: the 15 pairs holding the source index are skipped, a pair
// whose source triple is absent, or whose target lies in the pair and differs
// from the source, is dropped after the source read, and otherwise the target
// triple is read as well. After the result is issued the controller returns to
// idle and takes the next request there. A new request is taken while a result waits.
// ----------------------------------------------------------------------------
module gf2_cubic_tensor_transvection (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gct_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gct_pkg::rsp_t rsp
);

    gct_pkg::cmd_t cmd;
    gct_pkg::sts_t sts;

    gct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gct_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule
